FILE: rtl/aoc_pkg.sv
// ----------------------------------------------------------------------------
// aoc_pkg
// Shared widths and types for the alpha-over compositor pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package aoc_pkg;

  localparam int ChanW    = 8;
  localparam int NumChan  = 3;
  localparam int WeightW  = 2 * ChanW;
  localparam int SumW     = 2 * ChanW;
  localparam int NumW     = 3 * ChanW;
  localparam int DivSteps = ChanW;

  localparam logic [ChanW-1:0] ChanMax = '1;

  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    logic [NumChan-1:0][NumW-1:0]  rem;
    logic [NumChan-1:0][ChanW-1:0] quo;
    logic [SumW-1:0]               sum;
    logic [ChanW-1:0]              alpha;
  } aoc_div_t;

endpackage

`default_nettype wire

FILE: rtl/aoc_in_if.sv
// ----------------------------------------------------------------------------
// aoc_in_if
// Pixel pair channel: foreground and background RGBA with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface aoc_in_if
  import aoc_pkg::*;
();

  logic  valid;
  logic  ready;
  chan_t fg_red;
  chan_t fg_green;
  chan_t fg_blue;
  chan_t fg_alpha;
  chan_t bg_red;
  chan_t bg_green;
  chan_t bg_blue;
  chan_t bg_alpha;

  modport source (
    output valid, fg_red, fg_green, fg_blue, fg_alpha,
           bg_red, bg_green, bg_blue, bg_alpha,
    input  ready
  );

  modport sink (
    input  valid, fg_red, fg_green, fg_blue, fg_alpha,
           bg_red, bg_green, bg_blue, bg_alpha,
    output ready
  );

endinterface

`default_nettype wire

FILE: rtl/aoc_out_if.sv
// ----------------------------------------------------------------------------
// aoc_out_if
// Composite pixel channel: RGBA with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface aoc_out_if
  import aoc_pkg::*;
();

  logic  valid;
  logic  ready;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;
  chan_t out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );

endinterface

`default_nettype wire

FILE: rtl/aoc_divider.sv
// ----------------------------------------------------------------------------
// aoc_divider
// Pipelined restoring divider, one quotient bit per stage, three channels
// sharing one divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module aoc_divider
  import aoc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire aoc_div_t data_i,
  output logic          valid_o,
  input  wire logic     ready_i,
  output aoc_div_t      data_o
);

  aoc_div_t                stg_in [DivSteps];
  aoc_div_t                stg_d  [DivSteps];
  aoc_div_t                stg_q  [DivSteps];
  logic     [DivSteps-1:0] vld_q;
  logic     [DivSteps-1:0] en;

  // Stall chain: a stage may load when empty or when its successor loads.
  always_comb begin
    en[DivSteps-1] = !vld_q[DivSteps-1] || ready_i;
    for (int i = DivSteps - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_stage
    localparam int Sh = DivSteps - 1 - i;

    logic [NumW-1:0] dvs;
    logic            vin;

    if (i == 0) begin : g_first
      assign stg_in[i] = data_i;
      assign vin       = valid_i;
    end else begin : g_next
      assign stg_in[i] = stg_q[i-1];
      assign vin       = vld_q[i-1];
    end

    assign dvs = NumW'(stg_in[i].sum) << Sh;

    always_comb begin
      stg_d[i] = stg_in[i];
      for (int c = 0; c < NumChan; c++) begin
        if (stg_in[i].rem[c] >= dvs) begin
          stg_d[i].rem[c]     = stg_in[i].rem[c] - dvs;
          stg_d[i].quo[c][Sh] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en[i]) begin
        vld_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[i]) begin
        stg_q[i] <= stg_d[i];
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = vld_q[DivSteps-1];
  assign data_o  = stg_q[DivSteps-1];

endmodule

`default_nettype wire

FILE: rtl/alpha_over_compositor.sv
// ----------------------------------------------------------------------------
// alpha_over_compositor
// Porter-Duff over with straight alpha, exact integer quotients.
// ----------------------------------------------------------------------------
// Pipeline: 3 weight and sum stages, then 8 divider stages, one quotient
//   bit each. Throughput: one pixel per cycle while the sink is ready;
//   every stage loads when empty or draining.
// Reset: asynchronous, active low; clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_over_compositor
  import aoc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  aoc_in_if.sink    pix_i,
  aoc_out_if.source pix_o
);

  // stage 1: weights
  logic                            v1_q;
  logic [NumChan-1:0][ChanW-1:0]   cf1_q, cb1_q;
  logic [WeightW-1:0]              wf1_q, wb1_q;
  logic [WeightW-1:0]              wf1_d, wb1_d;

  // stage 2: products and weight sum
  logic                            v2_q;
  logic [NumChan-1:0][NumW-1:0]    pf2_q, pb2_q;
  logic [SumW-1:0]                 sum2_q;

  // stage 3: numerators and alpha
  logic                            v3_q;
  aoc_div_t                        s3_q, s3_d;
  logic [SumW:0]                   alpha_t;

  logic                            en1, en2, en3;
  logic                            div_ready;
  logic                            div_valid;
  aoc_div_t                        div_out;
  logic                            div_zero;

  assign en3         = !v3_q || div_ready;
  assign en2         = !v2_q || en3;
  assign en1         = !v1_q || en2;
  assign pix_i.ready = en1;

  assign wf1_d = {pix_i.fg_alpha, ChanW'(0)} - WeightW'(pix_i.fg_alpha);
  assign wb1_d = WeightW'(pix_i.bg_alpha) * WeightW'(ChanMax - pix_i.fg_alpha);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= pix_i.valid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cf1_q <= {pix_i.fg_blue, pix_i.fg_green, pix_i.fg_red};
      cb1_q <= {pix_i.bg_blue, pix_i.bg_green, pix_i.bg_red};
      wf1_q <= wf1_d;
      wb1_q <= wb1_d;
    end
    if (en2) begin
      sum2_q <= SumW'(wf1_q + wb1_q);
      for (int c = 0; c < NumChan; c++) begin
        pf2_q[c] <= NumW'(cf1_q[c]) * NumW'(wf1_q);
        pb2_q[c] <= NumW'(cb1_q[c]) * NumW'(wb1_q);
      end
    end
    if (en3) begin
      s3_q <= s3_d;
    end
  end

  // floor(sum / 255) for sums up to 255 * 255
  assign alpha_t = (SumW+1)'(sum2_q) + (SumW+1)'(1) + (SumW+1)'(sum2_q >> ChanW);

  always_comb begin
    s3_d.sum   = sum2_q;
    s3_d.alpha = alpha_t[SumW-1:ChanW];
    s3_d.quo   = '0;
    for (int c = 0; c < NumChan; c++) begin
      s3_d.rem[c] = pf2_q[c] + pb2_q[c];
    end
  end

  aoc_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .ready_o (div_ready),
    .data_i  (s3_q),
    .valid_o (div_valid),
    .ready_i (pix_o.ready),
    .data_o  (div_out)
  );

  // drop colors when the result is fully transparent
  assign div_zero        = (div_out.sum == '0);
  assign pix_o.valid     = div_valid;
  assign pix_o.out_red   = div_zero ? '0 : div_out.quo[0];
  assign pix_o.out_green = div_zero ? '0 : div_out.quo[1];
  assign pix_o.out_blue  = div_zero ? '0 : div_out.quo[2];
  assign pix_o.out_alpha = div_out.alpha;

  a_zero_sum_zero_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && (s3_q.sum == '0) |-> (s3_q.rem == '0))
    else $error("zero weight sum with nonzero numerator");

  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> v1_q && v2_q && v3_q)
    else $error("input stalled while a front stage is empty");

  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_valid && !div_zero |->
      (div_out.rem[0] < NumW'(div_out.sum)) &&
      (div_out.rem[1] < NumW'(div_out.sum)) &&
      (div_out.rem[2] < NumW'(div_out.sum)))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the alpha-over compositor. A directed table covers
// transparent, opaque and one-sided alpha corners, then about a thousand
// random pixel pairs follow with random gaps and stalls on both channels.
// Each pixel is checked against its table entry or an integer-exact predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import aoc_pkg::*;

  localparam int NumRandom   = 1000;
  localparam int HoldCycles  = 80;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 20;

  typedef struct packed {
    chan_t fr, fgc, fb, fa;
    chan_t br, bgc, bb, ba;
  } pix_pair_t;

  typedef struct packed {
    chan_t r, g, b, a;
  } rgba_t;

  typedef struct packed {
    pix_pair_t px;
    logic      known;
    rgba_t     res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  aoc_in_if  pair_if ();
  aoc_out_if comp_if ();

  alpha_over_compositor dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pair_if),
    .pix_o  (comp_if)
  );

  pix_pair_t   drive_px = '0;
  rgba_t       comp_q[$];
  int unsigned fail_cnt = 0;
  int unsigned stall_cnt = 0;
  int unsigned gapless_left = 0;
  bit          idle_en = 1'b1;
  bit          long_hold_req = 1'b0;
  rgba_t       want_px;
  chan_t       want_ch[4];
  chan_t       got_ch[4];
  string       ch_name[4] = '{"out_red", "out_green", "out_blue", "out_alpha"};

  stim_row_t dir_rows[18] = '{
    '{'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd0}},
    '{'{8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd0}},
    '{'{8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255}, 1'b1,
      '{8'd255, 8'd0, 8'd255, 8'd255}},
    '{'{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0}, 1'b1,
      '{8'd0, 8'd255, 8'd0, 8'd255}},
    '{'{8'd12, 8'd34, 8'd56, 8'd0, 8'd200, 8'd100, 8'd50, 8'd255}, 1'b1,
      '{8'd200, 8'd100, 8'd50, 8'd255}},
    '{'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 8'd255}},
    '{'{8'd255, 8'd255, 8'd255, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 8'd1}},
    '{'{8'd9, 8'd9, 8'd9, 8'd0, 8'd1, 8'd2, 8'd3, 8'd1}, 1'b1,
      '{8'd1, 8'd2, 8'd3, 8'd1}},
    '{'{8'd10, 8'd20, 8'd30, 8'd200, 8'd7, 8'd7, 8'd7, 8'd0}, 1'b1,
      '{8'd10, 8'd20, 8'd30, 8'd200}},
    '{'{8'd99, 8'd99, 8'd99, 8'd0, 8'd40, 8'd50, 8'd60, 8'd77}, 1'b1,
      '{8'd40, 8'd50, 8'd60, 8'd77}},
    '{'{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd255}},
    '{'{8'hAA, 8'h55, 8'hAA, 8'd127, 8'h55, 8'hAA, 8'h55, 8'd200}, 1'b0, '0},
    '{'{8'd255, 8'd0, 8'd128, 8'd128, 8'd0, 8'd255, 8'd127, 8'd128}, 1'b0, '0},
    '{'{8'd200, 8'd10, 8'd90, 8'd254, 8'd3, 8'd250, 8'd60, 8'd255}, 1'b0, '0},
    '{'{8'd1, 8'd254, 8'd100, 8'd1, 8'd254, 8'd1, 8'd100, 8'd254}, 1'b0, '0},
    '{'{8'd0, 8'd255, 8'd17, 8'd64, 8'd255, 8'd0, 8'd33, 8'd32}, 1'b0, '0},
    '{'{8'h80, 8'h7F, 8'h01, 8'h80, 8'h7F, 8'h80, 8'hFE, 8'h7F}, 1'b0, '0},
    '{'{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 8'd255}}
  };

  assign pair_if.fg_red   = drive_px.fr;
  assign pair_if.fg_green = drive_px.fgc;
  assign pair_if.fg_blue  = drive_px.fb;
  assign pair_if.fg_alpha = drive_px.fa;
  assign pair_if.bg_red   = drive_px.br;
  assign pair_if.bg_green = drive_px.bgc;
  assign pair_if.bg_blue  = drive_px.bb;
  assign pair_if.bg_alpha = drive_px.ba;

  function automatic chan_t mix_channel(chan_t cf, chan_t cb, int unsigned wf,
                                        int unsigned wb, int unsigned wsum);
    int unsigned q;
    if (wsum == 0) begin
      return '0;
    end
    q = (int'(cf) * wf + int'(cb) * wb) / wsum;
    return (q > int'(ChanMax)) ? ChanMax : chan_t'(q);
  endfunction

  function automatic rgba_t composite_over(pix_pair_t p);
    int unsigned cmax;
    int unsigned wf;
    int unsigned wb;
    int unsigned wsum;
    int unsigned a;
    rgba_t       r;
    cmax = ChanMax;
    wf   = int'(p.fa) * cmax;
    wb   = int'(p.ba) * (cmax - int'(p.fa));
    wsum = wf + wb;
    a    = wsum / cmax;
    r.r  = mix_channel(p.fr, p.br, wf, wb, wsum);
    r.g  = mix_channel(p.fgc, p.bgc, wf, wb, wsum);
    r.b  = mix_channel(p.fb, p.bb, wf, wb, wsum);
    r.a  = (a > cmax) ? ChanMax : chan_t'(a);
    return r;
  endfunction

  function automatic chan_t pick_alpha();
    case ($urandom_range(0, 5))
      0: begin
        return '0;
      end
      1: begin
        return ChanMax;
      end
      2: begin
        return chan_t'($urandom_range(1, 3));
      end
      3: begin
        return chan_t'($urandom_range(252, 254));
      end
      default: begin
        return chan_t'($urandom_range(0, 255));
      end
    endcase
  endfunction

  function automatic pix_pair_t random_pair();
    pix_pair_t p;
    p    = {$urandom, $urandom};
    p.fa = pick_alpha();
    p.ba = pick_alpha();
    return p;
  endfunction

  task automatic send_pair(pix_pair_t p, rgba_t res);
    drive_px      <= p;
    pair_if.valid <= 1'b1;
    @(posedge clk);
    while (!pair_if.ready) @(posedge clk);
    comp_q.push_back(res);
    if (gapless_left > 0) begin
      gapless_left--;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      pair_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    pix_pair_t p;
    rst_n         <= 1'b0;
    pair_if.valid <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[k]) begin
      send_pair(dir_rows[k].px,
                dir_rows[k].known ? dir_rows[k].res : composite_over(dir_rows[k].px));
    end
    for (int i = 0; i < NumRandom; i++) begin
      if (i == 300) begin
        long_hold_req = 1'b1;
        gapless_left  = 60;
      end
      if (i == 600) begin
        pair_if.valid <= 1'b0;
        do @(posedge clk); while (comp_q.size() != 0);
      end
      if (i == NumRandom - 200) begin
        idle_en = 1'b0;
      end
      p = random_pair();
      send_pair(p, composite_over(p));
    end
    pair_if.valid <= 1'b0;
    while (comp_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hold off the sink, in bursts or in one long stretch
  initial begin
    comp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        comp_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        comp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        comp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && comp_if.valid && comp_if.ready) begin
      if (comp_q.size() == 0) begin
        $error("composite pixel transfer with none pending");
        fail_cnt++;
      end else begin
        want_px = comp_q.pop_front();
        want_ch = '{want_px.r, want_px.g, want_px.b, want_px.a};
        got_ch  = '{comp_if.out_red, comp_if.out_green, comp_if.out_blue,
                    comp_if.out_alpha};
        foreach (want_ch[c]) begin
          if (got_ch[c] !== want_ch[c]) begin
            $error("%s: expected %0d, got %0d", ch_name[c], want_ch[c], got_ch[c]);
            fail_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((pair_if.valid && pair_if.ready) || (comp_if.valid && comp_if.ready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt == StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/aoc_pkg.sv
rtl/aoc_in_if.sv
rtl/aoc_out_if.sv
rtl/aoc_divider.sv
rtl/alpha_over_compositor.sv
verif/testbench.sv
